FILE: src/ipeth_pkg.sv
// Shared types and constants of the IP to Ethernet II encapsulator.
package ipeth_pkg;

  localparam int HEADER_BYTES = 14;
  localparam int MAC_BYTES = 6;
  localparam int TYPE_OFFSET = 12;
  localparam int DESC_FIFO_DEPTH = 4;
  localparam int STEP_W = $clog2(HEADER_BYTES + 1);

  localparam logic [47:0] MAC_RESET = 48'h0200_0000_0000;

  localparam logic [3:0] IP_VERSION_4 = 4'd4;
  localparam logic [3:0] IP_VERSION_6 = 4'd6;
  localparam logic [15:0] MIN_LEN_V4 = 16'd20;
  localparam logic [15:0] MIN_LEN_V6 = 16'd40;
  localparam logic [15:0] ETHERTYPE_V4 = 16'h0800;
  localparam logic [15:0] ETHERTYPE_V6 = 16'h86DD;

  typedef enum logic [2:0] {
    STATUS_OK            = 3'd0,
    STATUS_SHORT_V4      = 3'd1,
    STATUS_SHORT_V6      = 3'd2,
    STATUS_BAD_VERSION   = 3'd3,
    STATUS_CAP_OVER_WIRE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DESC_FRAME  = 2'd0,
    DESC_DROP   = 2'd1,
    DESC_HEADER = 2'd2
  } desc_kind_t;

  typedef enum logic [0:0] {
    CFG_DEST_ADDRESS   = 1'b0,
    CFG_SOURCE_ADDRESS = 1'b1
  } cfg_index_t;

  // One classified input word, handed from the front to the back.
  typedef struct packed {
    desc_kind_t  kind;
    logic [7:0]  data_byte;
    logic        last;
    logic        is_v6;
    logic [16:0] cap_len;
    logic [32:0] wire_len;
    status_t     status;
  } desc_t;

  // Handshake state of the descriptor queue as seen by its two users.
  typedef struct packed {
    logic full;
    logic valid;
  } fifo_status_t;

endpackage

FILE: src/ipeth_front.sv
// Front part: accept input words, check packet headers and track dropping.
module ipeth_front import ipeth_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_data_byte,
  input  logic        in_packet_start,
  input  logic        in_packet_end,
  input  logic [15:0] in_cap_length,
  input  logic [31:0] in_wire_length,
  input  fifo_status_t fifo_st,
  output logic        in_full,
  output logic        desc_push,
  output desc_t       desc_out
);

  logic    dropping_r, dropping_nxt;
  logic    accept;
  status_t status;
  logic [3:0] version;

  assign version = in_data_byte[7:4];
  assign in_full = fifo_st.full;
  assign accept  = in_push && !fifo_st.full;

  always_comb begin
    if ({16'd0, in_cap_length} > in_wire_length) begin
      status = STATUS_CAP_OVER_WIRE;
    end else if (in_cap_length == 16'd0) begin
      status = STATUS_BAD_VERSION;
    end else if (version == IP_VERSION_4) begin
      status = (in_cap_length < MIN_LEN_V4) ? STATUS_SHORT_V4 : STATUS_OK;
    end else if (version == IP_VERSION_6) begin
      status = (in_cap_length < MIN_LEN_V6) ? STATUS_SHORT_V6 : STATUS_OK;
    end else begin
      status = STATUS_BAD_VERSION;
    end
  end

  always_comb begin
    dropping_nxt      = dropping_r;
    desc_push         = 1'b0;
    desc_out.kind     = DESC_FRAME;
    desc_out.data_byte = in_data_byte;
    desc_out.last     = in_packet_end;
    desc_out.is_v6    = (version == IP_VERSION_6);
    desc_out.cap_len  = {1'b0, in_cap_length} + 17'(HEADER_BYTES);
    desc_out.wire_len = {1'b0, in_wire_length} + 33'(HEADER_BYTES);
    desc_out.status   = status;
    if (accept) begin
      if (in_packet_start) begin
        desc_push = 1'b1;
        if (status != STATUS_OK) begin
          desc_out.kind = DESC_DROP;
          dropping_nxt  = !in_packet_end;
        end else begin
          desc_out.kind = DESC_HEADER;
          dropping_nxt  = 1'b0;
        end
      end else if (dropping_r) begin
        // swallow the rest of a rejected packet
        if (in_packet_end) begin
          dropping_nxt = 1'b0;
        end
      end else begin
        desc_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dropping_r <= 1'b0;
    end else begin
      dropping_r <= dropping_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_drop_starts_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dropping_r) |-> $past(accept && in_packet_start))
    else $error("dropping began without an accepted start word");
`endif

endmodule

FILE: src/ipeth_desc_fifo.sv
// Short descriptor queue between the front and the back.
module ipeth_desc_fifo import ipeth_pkg::*; #(
  parameter int DEPTH = DESC_FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  desc_t        push_data,
  input  logic         pop,
  output desc_t        head,
  output fifo_status_t st
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t           mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign st.full  = (count_r == CW'(DEPTH));
  assign st.valid = (count_r != '0);
  assign do_push  = push && !st.full;
  assign do_pop   = pop && st.valid;
  assign head     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("descriptor queue count beyond depth");
`endif

endmodule

FILE: src/ipeth_back.sv
// Back part: expand descriptors into result words through the output register.
module ipeth_back import ipeth_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [47:0]  dest_address,
  input  logic [47:0]  source_address,
  input  desc_t        desc,
  input  fifo_status_t fifo_st,
  output logic         desc_pop,
  input  logic         out_pop,
  output logic         out_empty,
  output logic [7:0]   out_frame_byte,
  output logic         out_byte_valid,
  output logic         out_frame_start,
  output logic         out_frame_end,
  output logic [16:0]  out_frame_cap_length,
  output logic [32:0]  out_frame_wire_length,
  output logic [2:0]   out_status,
  output logic         out_run_last
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              bvalid_r, bvalid_nxt;
  logic              start_r, start_nxt;
  logic              end_r, end_nxt;
  logic [16:0]       capl_r, capl_nxt;
  logic [32:0]       wirel_r, wirel_nxt;
  status_t           status_r, status_nxt;
  logic              last_r, last_nxt;
  logic              advance, emit;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] idx);
    logic [47:0] shifted;
    shifted = mac >> {3'(MAC_BYTES - 1) - idx, 3'b000};
    return shifted[7:0];
  endfunction

  function automatic logic [7:0] header_byte(input logic [47:0] dmac, input logic [47:0] smac,
                                             input logic v6, input logic [STEP_W-1:0] idx);
    logic [15:0] etype;
    etype = v6 ? ETHERTYPE_V6 : ETHERTYPE_V4;
    if (idx < STEP_W'(MAC_BYTES)) begin
      return mac_byte(dmac, idx[2:0]);
    end else if (idx < STEP_W'(2 * MAC_BYTES)) begin
      return mac_byte(smac, 3'(idx - STEP_W'(MAC_BYTES)));
    end else if (idx == STEP_W'(TYPE_OFFSET)) begin
      return etype[15:8];
    end else begin
      return etype[7:0];
    end
  endfunction

  assign out_empty = !out_valid_r;
  assign advance   = !out_valid_r || out_pop;
  assign emit      = advance && fifo_st.valid;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = advance ? 1'b0 : out_valid_r;
    desc_pop      = 1'b0;
    byte_nxt      = byte_r;
    bvalid_nxt    = bvalid_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    capl_nxt      = capl_r;
    wirel_nxt     = wirel_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = desc.data_byte;
      bvalid_nxt    = 1'b1;
      start_nxt     = 1'b0;
      end_nxt       = desc.last;
      capl_nxt      = '0;
      wirel_nxt     = '0;
      status_nxt    = STATUS_OK;
      last_nxt      = 1'b1;
      desc_pop      = 1'b1;
      case (desc.kind)
        DESC_HEADER: begin
          if (step_r != STEP_W'(HEADER_BYTES)) begin
            // header byte: hold the descriptor and advance the step
            byte_nxt  = header_byte(dest_address, source_address, desc.is_v6, step_r);
            end_nxt   = 1'b0;
            last_nxt  = 1'b0;
            desc_pop  = 1'b0;
            step_nxt  = step_r + 1'b1;
            if (step_r == '0) begin
              start_nxt = 1'b1;
              capl_nxt  = desc.cap_len;
              wirel_nxt = desc.wire_len;
            end
          end else begin
            step_nxt = '0;
          end
        end
        DESC_DROP: begin
          byte_nxt   = '0;
          bvalid_nxt = 1'b0;
          end_nxt    = 1'b0;
          status_nxt = desc.status;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    bvalid_r <= bvalid_nxt;
    start_r  <= start_nxt;
    end_r    <= end_nxt;
    capl_r   <= capl_nxt;
    wirel_r  <= wirel_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  assign out_frame_byte        = byte_r;
  assign out_byte_valid        = bvalid_r;
  assign out_frame_start       = start_r;
  assign out_frame_end         = end_r;
  assign out_frame_cap_length  = capl_r;
  assign out_frame_wire_length = wirel_r;
  assign out_status            = status_r;
  assign out_run_last          = last_r;

`ifndef NO_ASSERTIONS
  a_step_on_header: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != '0) |-> (fifo_st.valid && desc.kind == DESC_HEADER))
    else $error("header step pending without a header descriptor at the head");

  a_start_is_ok_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && start_r) |-> (bvalid_r && status_r == STATUS_OK && !last_r))
    else $error("frame start word is not a plain header byte");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_W'(HEADER_BYTES))
    else $error("header step beyond header length");
`endif

endmodule

FILE: src/ip_to_ethernet_encapsulator.sv
// Top level of the IP to Ethernet II encapsulator.
//
// Takes raw IP packets one byte word per cycle and emits Ethernet II frames
// as result words. The first word of a packet (in_packet_start) carries the
// captured and wire lengths. A packet whose captured length exceeds its wire
// length, whose version nibble is not 4 or 6, whose captured length is zero,
// or that is shorter than 20 (IPv4) or 40 (IPv6) bytes yields one drop word
// (out_byte_valid low, out_status giving the reason) and its remaining words
// are swallowed. An accepted packet gets the 14-byte header (destination MAC,
// source MAC, EtherType 0x0800 or 0x86DD) in front of its first byte; the
// lengths reported with out_frame_start are raised by 14. Both sides behave as
// queues: push/full on input, empty/pop on output. Rate: the front accepts one
// word per cycle while the descriptor queue (FIFO_DEPTH entries) has room; the
// back's header sequencer emits one result word per cycle while the output
// register is free or popped; a plain or drop word yields one result word and
// an accepted start word yields 15. Each result passes through the descriptor
// queue and is then loaded into the output register.
// The MAC registers are written through cfg_we/cfg_index/cfg_data and reset to
// 02:00:00:00:00:00; write them only while the block is idle.
module ip_to_ethernet_encapsulator import ipeth_pkg::*; #(
  parameter int FIFO_DEPTH = DESC_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [47:0] cfg_data,
  // input channel
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_packet_start,
  input  logic        in_packet_end,
  input  logic [15:0] in_cap_length,
  input  logic [31:0] in_wire_length,
  // result channel
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_frame_byte,
  output logic        out_byte_valid,
  output logic        out_frame_start,
  output logic        out_frame_end,
  output logic [16:0] out_frame_cap_length,
  output logic [32:0] out_frame_wire_length,
  output logic [2:0]  out_status,
  output logic        out_run_last
);

  logic [47:0]  dest_r, dest_nxt;
  logic [47:0]  src_r, src_nxt;
  logic         desc_push, desc_pop;
  desc_t        desc_in, desc_head;
  fifo_status_t fifo_st;

  // Hold the MAC addresses; update on a write to their index.
  always_comb begin
    dest_nxt = dest_r;
    src_nxt  = src_r;
    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_DEST_ADDRESS:   dest_nxt = cfg_data;
        CFG_SOURCE_ADDRESS: src_nxt  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= MAC_RESET;
      src_r  <= MAC_RESET;
    end else begin
      dest_r <= dest_nxt;
      src_r  <= src_nxt;
    end
  end

  // Classify each accepted word and drop swallowed ones.
  ipeth_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_data_byte    (in_data_byte),
    .in_packet_start (in_packet_start),
    .in_packet_end   (in_packet_end),
    .in_cap_length   (in_cap_length),
    .in_wire_length  (in_wire_length),
    .fifo_st         (fifo_st),
    .in_full         (in_full),
    .desc_push       (desc_push),
    .desc_out        (desc_in)
  );

  // Decouple the classifier from the header sequencer.
  ipeth_desc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_data (desc_in),
    .pop       (desc_pop),
    .head      (desc_head),
    .st        (fifo_st)
  );

  // Expand descriptors into frame words, header first.
  ipeth_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .dest_address          (dest_r),
    .source_address        (src_r),
    .desc                  (desc_head),
    .fifo_st               (fifo_st),
    .desc_pop              (desc_pop),
    .out_pop               (out_pop),
    .out_empty             (out_empty),
    .out_frame_byte        (out_frame_byte),
    .out_byte_valid        (out_byte_valid),
    .out_frame_start       (out_frame_start),
    .out_frame_end         (out_frame_end),
    .out_frame_cap_length  (out_frame_cap_length),
    .out_frame_wire_length (out_frame_wire_length),
    .out_status            (out_status),
    .out_run_last          (out_run_last)
  );

endmodule

FILE: sim/ip_to_ethernet_encapsulator_test.sv
// Self-checking testbench of the IP to Ethernet II encapsulator.
`timescale 1ns / 1ps

module ip_to_ethernet_encapsulator_test;
  import ipeth_pkg::*;

  // Cycles the receiver refuses words during the pressure batch.
  localparam int HOLD_CYCLES = 400;
  // Cycles without any word moving on either side before the run is declared hung.
  localparam int STALL_LIMIT = 3000;
  // Cycles to let the block settle once nothing more is expected.
  localparam int SETTLE_CYCLES = 8;
  // Countable words per random batch.
  localparam int BATCH_WORDS = 44;

  // One input word of the raw IP byte stream.
  typedef struct {
    logic [7:0]  data;
    logic        pkt_first;
    logic        pkt_last;
    logic [15:0] cap_len;
    logic [31:0] wire_len;
  } ip_word_t;

  // One result word of the Ethernet frame stream.
  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        fstart;
    logic        fend;
    logic [16:0] cap_len;
    logic [32:0] wire_len;
    status_t     status;
    logic        last;
  } frame_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_DEST_ADDRESS;
  logic [47:0] cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = '0;
  logic        in_packet_start = 1'b0;
  logic        in_packet_end = 1'b0;
  logic [15:0] in_cap_length = '0;
  logic [31:0] in_wire_length = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_frame_byte;
  logic        out_byte_valid;
  logic        out_frame_start;
  logic        out_frame_end;
  logic [16:0] out_frame_cap_length;
  logic [32:0] out_frame_wire_length;
  logic [2:0]  out_status;
  logic        out_run_last;

  ip_to_ethernet_encapsulator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_data_byte         (in_data_byte),
    .in_packet_start      (in_packet_start),
    .in_packet_end        (in_packet_end),
    .in_cap_length        (in_cap_length),
    .in_wire_length       (in_wire_length),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_frame_byte       (out_frame_byte),
    .out_byte_valid       (out_byte_valid),
    .out_frame_start      (out_frame_start),
    .out_frame_end        (out_frame_end),
    .out_frame_cap_length (out_frame_cap_length),
    .out_frame_wire_length(out_frame_wire_length),
    .out_status           (out_status),
    .out_run_last         (out_run_last)
  );

  // Words waiting to be offered, and frame words still owed by the block.
  ip_word_t    ip_bytes_q[$];
  frame_word_t owed_frame_q[$];

  // Shadow of the block: MAC registers and the drop flag.
  logic [47:0] dest_mac = MAC_RESET;
  logic [47:0] src_mac = MAC_RESET;
  bit          swallowing = 1'b0;

  ip_word_t    cur_word;
  frame_word_t got_w;
  frame_word_t want_w;
  bit          steady = 1'b0;        // no idling on either side while set
  bit          hold_request = 1'b0;  // ask the receiver for one long hold-off
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          error_count = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          frames_seen = 0;
  int          drops_seen = 0;
  int          mac_settings = 1;

  initial begin
    forever #5 clk = ~clk;
  end

  // Count one mismatch and print it on one line.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Work out the frame words that one accepted input word produces.
  function automatic void encapsulate(input ip_word_t w);
    status_t     st;
    logic [15:0] ether;
    logic [3:0]  ver;
    frame_word_t f;
    if (w.pkt_first) begin
      ver = w.data[7:4];
      st = STATUS_OK;
      ether = '0;
      // Check order: length relation, empty capture, version, minimum length.
      if (w.cap_len > w.wire_len) st = STATUS_CAP_OVER_WIRE;
      else if (w.cap_len == 0) st = STATUS_BAD_VERSION;
      else if (ver == IP_VERSION_4) begin
        if (w.cap_len < MIN_LEN_V4) st = STATUS_SHORT_V4;
        ether = ETHERTYPE_V4;
      end else if (ver == IP_VERSION_6) begin
        if (w.cap_len < MIN_LEN_V6) st = STATUS_SHORT_V6;
        ether = ETHERTYPE_V6;
      end else st = STATUS_BAD_VERSION;
      if (st != STATUS_OK) begin
        // Rejected: one drop word, swallow the rest unless this word ends it.
        f = '0;
        f.status = st;
        f.last = 1'b1;
        owed_frame_q.push_back(f);
        swallowing = !w.pkt_last;
        return;
      end
      swallowing = 1'b0;
      for (int i = 0; i < HEADER_BYTES; i++) begin
        f = '0;
        f.valid = 1'b1;
        if (i < MAC_BYTES) f.data = dest_mac[47 - 8 * i -: 8];
        else if (i < 2 * MAC_BYTES) f.data = src_mac[47 - 8 * (i - MAC_BYTES) -: 8];
        else if (i == TYPE_OFFSET) f.data = ether[15:8];
        else f.data = ether[7:0];
        if (i == 0) begin
          f.fstart = 1'b1;
          f.cap_len = {1'b0, w.cap_len} + 17'(HEADER_BYTES);
          f.wire_len = {1'b0, w.wire_len} + 33'(HEADER_BYTES);
        end
        owed_frame_q.push_back(f);
      end
      f = '0;
      f.valid = 1'b1;
      f.data = w.data;
      f.fend = w.pkt_last;
      f.last = 1'b1;
      owed_frame_q.push_back(f);
    end else if (swallowing) begin
      if (w.pkt_last) swallowing = 1'b0;
    end else begin
      // Plain byte, inside an accepted packet or outside any packet.
      f = '0;
      f.valid = 1'b1;
      f.data = w.data;
      f.fend = w.pkt_last;
      f.last = 1'b1;
      owed_frame_q.push_back(f);
    end
  endfunction

  // Driver: predict on each accepted word, then hold, advance or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        encapsulate(cur_word);
        words_sent++;
      end
      // Hold the offered word while the block is full.
      if (!in_push || !in_full) begin
        if (ip_bytes_q.size() != 0 && (steady || $urandom_range(99) >= 17)) begin
          cur_word = ip_bytes_q.pop_front();
          in_data_byte <= cur_word.data;
          in_packet_start <= cur_word.pkt_first;
          in_packet_end <= cur_word.pkt_last;
          in_cap_length <= cur_word.cap_len;
          in_wire_length <= cur_word.wire_len;
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped word against the oldest owed one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got_w = '{out_frame_byte, out_byte_valid, out_frame_start, out_frame_end,
                  out_frame_cap_length, out_frame_wire_length, status_t'(out_status),
                  out_run_last};
        words_checked++;
        if (got_w.fstart) frames_seen++;
        if (!got_w.valid) drops_seen++;
        if (owed_frame_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %p", got_w));
        end else begin
          want_w = owed_frame_q.pop_front();
          if (got_w.data !== want_w.data)
            report_mismatch($sformatf("frame_byte %0h, want %0h", got_w.data, want_w.data));
          if (got_w.valid !== want_w.valid)
            report_mismatch($sformatf("byte_valid %0b, want %0b", got_w.valid, want_w.valid));
          if (got_w.fstart !== want_w.fstart)
            report_mismatch($sformatf("frame_start %0b, want %0b",
                                      got_w.fstart, want_w.fstart));
          if (got_w.fend !== want_w.fend)
            report_mismatch($sformatf("frame_end %0b, want %0b", got_w.fend, want_w.fend));
          if (got_w.cap_len !== want_w.cap_len)
            report_mismatch($sformatf("frame_cap_length %0d, want %0d",
                                      got_w.cap_len, want_w.cap_len));
          if (got_w.wire_len !== want_w.wire_len)
            report_mismatch($sformatf("frame_wire_length %0d, want %0d",
                                      got_w.wire_len, want_w.wire_len));
          if (got_w.status !== want_w.status)
            report_mismatch($sformatf("status %0d, want %0d", got_w.status, want_w.status));
          if (got_w.last !== want_w.last)
            report_mismatch($sformatf("run_last %0b, want %0b", got_w.last, want_w.last));
        end
      end
      // A requested hold-off refuses words for a long stretch, so the block fills.
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= steady || ($urandom_range(99) >= 17);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d words still owed",
                 STALL_LIMIT, owed_frame_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic add_word(input logic [7:0] data, input bit first, input bit last_w,
                          input logic [15:0] cap_len, input logic [31:0] wire_len);
    ip_word_t w;
    w.data = data;
    w.pkt_first = first;
    w.pkt_last = last_w;
    w.cap_len = cap_len;
    w.wire_len = wire_len;
    ip_bytes_q.push_back(w);
  endtask

  // Queue a packet: head byte with lengths, then random body bytes.
  task automatic add_packet(input logic [7:0] head, input logic [15:0] cap_len,
                            input logic [31:0] wire_len, input int n_bytes, input bit closed);
    add_word(head, 1'b1, closed && n_bytes == 1, cap_len, wire_len);
    for (int i = 1; i < n_bytes; i++)
      add_word(8'($urandom), 1'b0, closed && i == n_bytes - 1, 16'($urandom), $urandom);
  endtask

  // Random mix: mostly accepted packets, then rejected ones, stray bytes and
  // packets cut short by the next start.
  task automatic add_random_words(input int target);
    int          counted;
    int          pick;
    int          n;
    logic [3:0]  ver;
    logic [15:0] cap_len;
    logic [31:0] wire_len;
    bit          v6;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        v6 = 1'($urandom_range(1));
        ver = v6 ? IP_VERSION_6 : IP_VERSION_4;
        cap_len = 16'(v6 ? $urandom_range(40, 56) : $urandom_range(20, 36));
        if ($urandom_range(3) == 0) wire_len = $urandom;
        else wire_len = cap_len + $urandom_range(0, 1500);
        // Full-length body now and then; short bodies keep the run brisk.
        n = $urandom_range(2) == 0 ? int'(cap_len) : $urandom_range(1, 8);
        add_packet({ver, 4'($urandom)}, cap_len, wire_len, n, 1'b1);
        counted += n;
      end else if (pick < 80) begin
        ver = 4'($urandom);
        wire_len = '0;
        case ($urandom_range(4))
          0: begin
            cap_len = 16'($urandom_range(1, 65535));
            wire_len = $urandom_range(0, int'(cap_len) - 1);
          end
          1: begin
            cap_len = '0;
            wire_len = $urandom;
          end
          2: begin
            while (ver == IP_VERSION_4 || ver == IP_VERSION_6) ver = 4'($urandom);
            cap_len = 16'($urandom);
          end
          3: begin
            ver = IP_VERSION_4;
            cap_len = 16'($urandom_range(1, 19));
          end
          default: begin
            ver = IP_VERSION_6;
            cap_len = 16'($urandom_range(1, 39));
          end
        endcase
        if (cap_len != 0 && ver != 0 && pick != 0) begin
          // keep the over-wire case intact; elsewhere make wire at least cap
          if (!(wire_len < cap_len && wire_len != 0)) begin
            wire_len = $urandom;
            if (wire_len < cap_len) wire_len = cap_len;
          end
        end
        add_packet({ver, 4'($urandom)}, cap_len, wire_len, $urandom_range(1, 6),
                   $urandom_range(7) != 0);
        counted++;
      end else if (pick < 90) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          add_word(8'($urandom), 1'b0, 1'($urandom_range(1)), 16'($urandom), $urandom);
        counted += n;
      end else begin
        v6 = 1'($urandom_range(1));
        n = $urandom_range(1, 5);
        add_packet({v6 ? IP_VERSION_6 : IP_VERSION_4, 4'($urandom)},
                   v6 ? 16'd60 : 16'd30, 32'd1500, n, 1'b0);
        counted += n;
      end
    end
  endtask

  // Wait until nothing is offered or owed, then let swallowed words drain.
  task automatic wait_idle();
    while (ip_bytes_q.size() != 0 || in_push || owed_frame_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mac(input cfg_index_t idx, input logic [47:0] mac);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= mac;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEST_ADDRESS) dest_mac = mac;
    else src_mac = mac;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words, run on the reset MAC addresses.
    add_word(8'h00, 1'b0, 1'b0, 16'h0000, 32'h0000_0000);     // stray byte after reset
    add_word(8'hFF, 1'b0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);     // stray end byte
    add_word(8'h45, 1'b1, 1'b0, 16'd20, 32'd20);              // shortest IPv4
    add_word(8'hA5, 1'b0, 1'b1, 16'h0000, 32'h0000_0000);
    add_word(8'h60, 1'b1, 1'b1, 16'd40, 32'hFFFF_FFFF);       // shortest IPv6, start is end
    add_word(8'h45, 1'b1, 1'b0, 16'd19, 32'd100);             // short IPv4
    add_word(8'h11, 1'b0, 1'b0, 16'd0, 32'd0);                // swallowed
    add_word(8'h22, 1'b0, 1'b1, 16'd0, 32'd0);                // swallowed, ends drop
    add_word(8'h33, 1'b0, 1'b0, 16'd0, 32'd0);                // byte outside a packet
    add_word(8'h6F, 1'b1, 1'b1, 16'd39, 32'd39);              // short IPv6, start is end
    add_word(8'h55, 1'b1, 1'b0, 16'd30, 32'd30);              // unknown version
    add_word(8'h45, 1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);     // start while dropping
    add_word(8'h00, 1'b0, 1'b0, 16'd0, 32'd0);
    add_word(8'h45, 1'b1, 1'b0, 16'd100, 32'd99);             // captured over wire
    add_word(8'hFF, 1'b0, 1'b1, 16'd0, 32'd0);                // swallowed
    add_word(8'h45, 1'b1, 1'b1, 16'd0, 32'd0);                // zero captured length
    add_word(8'h6A, 1'b1, 1'b0, 16'hFFFF, 32'h0000_FFFF);     // IPv6, abandoned below
    add_word(8'h46, 1'b1, 1'b0, 16'd20, 32'd20);              // start while in a packet
    add_word(8'hC3, 1'b0, 1'b1, 16'd0, 32'd0);
    add_word(8'h00, 1'b1, 1'b1, 16'hFFFF, 32'd0);             // over wire, version 0
    add_word(8'hF0, 1'b1, 1'b1, 16'd1, 32'd1);                // version 15
    wait_idle();

    // Extreme MACs, with the normal idle mix.
    write_mac(CFG_DEST_ADDRESS, 48'h0);
    write_mac(CFG_SOURCE_ADDRESS, 48'hFFFF_FFFF_FFFF);
    mac_settings++;
    add_random_words(BATCH_WORDS);
    wait_idle();

    // Swapped extremes; stall the output long enough to fill the block.
    write_mac(CFG_DEST_ADDRESS, 48'hFFFF_FFFF_FFFF);
    write_mac(CFG_SOURCE_ADDRESS, 48'h0);
    mac_settings++;
    hold_request = 1'b1;
    add_random_words(BATCH_WORDS);
    wait_idle();

    // Random MACs at full rate on both sides.
    write_mac(CFG_DEST_ADDRESS, {16'($urandom), 32'($urandom)});
    write_mac(CFG_SOURCE_ADDRESS, {16'($urandom), 32'($urandom)});
    mac_settings++;
    steady = 1'b1;
    add_random_words(BATCH_WORDS);
    wait_idle();
    steady = 1'b0;

    write_mac(CFG_DEST_ADDRESS, {16'($urandom), 32'($urandom)});
    write_mac(CFG_SOURCE_ADDRESS, {16'($urandom), 32'($urandom)});
    mac_settings++;
    add_random_words(BATCH_WORDS);
    wait_idle();
    // Catch any late stray word.
    repeat (20) @(posedge clk);

    $display("Run covered %0d input words and %0d result words (%0d frames, %0d drops)",
             words_sent, words_checked, frames_seen, drops_seen);
    $display("across %0d MAC settings, a %0d-cycle output hold-off and a full-rate batch",
             mac_settings, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ipeth_pkg.sv
src/ipeth_front.sv
src/ipeth_desc_fifo.sv
src/ipeth_back.sv
src/ip_to_ethernet_encapsulator.sv
sim/ip_to_ethernet_encapsulator_test.sv
